// ----- hw/rtl/json_token_scanner_unit_assert.svh -----
// ----------------------------------------------------------------------------
// JSON token scanner assertion macros
// Shorthand for the concurrent checks that watch the scanner's ports.
// ----------------------------------------------------------------------------
`ifndef JSON_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define JSON_TOKEN_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define JTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define JTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/jts_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON token scanner package
// Token kinds, error causes, scan modes and character codes shared by the
// scanner and its checker.
// ----------------------------------------------------------------------------
package jts_pkg;

  localparam int OFFSET_WIDTH = 16;

  typedef logic [OFFSET_WIDTH-1:0] offset_t;

  typedef enum logic [3:0] {
    KIND_END      = 4'd0,
    KIND_NUMBER   = 4'd1,
    KIND_STRING   = 4'd2,
    KIND_NULL     = 4'd3,
    KIND_TRUE     = 4'd4,
    KIND_FALSE    = 4'd5,
    KIND_COMMA    = 4'd6,
    KIND_COLON    = 4'd7,
    KIND_LBRACE   = 4'd8,
    KIND_RBRACE   = 4'd9,
    KIND_LBRACKET = 4'd10,
    KIND_RBRACKET = 4'd11,
    KIND_ERROR    = 4'd13
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_NONE         = 2'd0,
    CAUSE_UNTERMINATED = 2'd1,
    CAUSE_NEWLINE      = 2'd2,
    CAUSE_UNEXPECTED   = 2'd3
  } cause_t;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_NUM  = 4'b0010,
    MODE_WORD = 4'b0100,
    MODE_STR  = 4'b1000
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    cause_t      cause;
    logic        last;
  } result_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D9     = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LBRKT  = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRKT  = 8'h5D;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Bit 0 keeps "null", bit 1 "true" and bit 2 "false" alive when the
  // character at position idx of the word matches that keyword.
  function automatic logic [2:0] kw_hits(input logic [15:0] idx, input logic [7:0] c);
    logic [7:0] n_ch;
    logic [7:0] t_ch;
    logic [7:0] f_ch;
    logic       in4;
    logic       in5;
    in4 = (idx < 16'd4);
    in5 = (idx < 16'd5);
    case (idx[2:0])
      3'd0: begin n_ch = "n"; t_ch = "t"; f_ch = "f"; end
      3'd1: begin n_ch = "u"; t_ch = "r"; f_ch = "a"; end
      3'd2: begin n_ch = "l"; t_ch = "u"; f_ch = "l"; end
      3'd3: begin n_ch = "l"; t_ch = "e"; f_ch = "s"; end
      3'd4: begin n_ch = CH_NUL; t_ch = CH_NUL; f_ch = "e"; end
      default: begin n_ch = CH_NUL; t_ch = CH_NUL; f_ch = CH_NUL; end
    endcase
    return {in5 && (c == f_ch), in4 && (c == t_ch), in4 && (c == n_ch)};
  endfunction

endpackage

// ----- hw/rtl/jts_if.sv -----
// ----------------------------------------------------------------------------
// JSON token scanner channels
// Valid/ready channels for text bytes in and tokens out.
// ----------------------------------------------------------------------------
interface jts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source(output valid, output text_byte, output end_of_text, input ready);
  modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jts_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [1:0]  error_cause;
  logic        last_of_run;

  modport source(output valid, output token_kind, output token_start,
                 output token_length, output error_cause, output last_of_run,
                 input ready);
  modport sink(input valid, input token_kind, input token_start,
               input token_length, input error_cause, input last_of_run,
               output ready);
endinterface

// ----- hw/rtl/json_token_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// JSON token scanner
// Tokenizes a JSON text one byte per request into kind, start and length.
// ----------------------------------------------------------------------------
//   Channel  | Direction | Payload
//   ---------+-----------+----------------------------------------------------
//   in_chan  | in        | text_byte, end_of_text
//   out_chan | out       | token_kind, token_start, token_length,
//            |           | error_cause, last_of_run
//
// A byte is first registered in the input register; then its scan and the
// results it causes are written into a four-entry result queue.
// The input takes a byte every cycle while the queue holds at most one
// result; a byte that causes two or three results can raise the count above
// one and so hold the input. Tokens leave the queue one per cycle in order
// while out_chan.ready is high; out_chan.ready never reaches in_chan.ready
// combinationally. rst_n is synchronous; it clears the scan state and empties
// the input register and the queue.
// ----------------------------------------------------------------------------
module json_token_scanner_unit (
  input  logic             clk,
  input  logic             rst_n,
  jts_in_if.sink           in_chan,
  jts_out_if.source        out_chan
);

  typedef logic [jts_pkg::OFFSET_WIDTH-1:0] pos_t;

  logic [7:0]      byte_r;
  logic            eot_r;
  logic            vld_r;
  logic            vld_nxt;

  jts_pkg::mode_t  mode_r, mode_nxt;
  logic            esc_r, esc_nxt;
  pos_t            pos_r, pos_nxt;
  pos_t            rstart_r, rstart_nxt;
  logic [15:0]     rlen_r, rlen_nxt;
  logic [2:0]      kc_r, kc_nxt;
  logic            halt_r, halt_nxt;

  jts_pkg::result_t res [3];
  logic [1:0]      n_res;

  jts_pkg::result_t q_r [4];
  jts_pkg::result_t q_nxt [4];
  logic [2:0]      cnt_r, cnt_nxt;

  logic            in_take;
  logic            mv;
  logic            pop;
  logic [2:0]      rem;
  pos_t            p1;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= jts_pkg::CH_LA) && (c <= jts_pkg::CH_LZ)) ||
           ((c >= jts_pkg::CH_UA) && (c <= jts_pkg::CH_UZ));
  endfunction

  function automatic logic is_num_cont(input logic [7:0] c);
    return ((c >= jts_pkg::CH_D0) && (c <= jts_pkg::CH_D9)) ||
           ((c >= jts_pkg::CH_LA) && (c <= jts_pkg::CH_LF_HEX)) ||
           ((c >= jts_pkg::CH_UA) && (c <= jts_pkg::CH_UF)) ||
           (c == jts_pkg::CH_DOT) || (c == jts_pkg::CH_MINUS) ||
           (c == jts_pkg::CH_PLUS);
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  function automatic jts_pkg::result_t mk_tok(input jts_pkg::kind_t k, input pos_t s,
                                              input logic [15:0] len,
                                              input jts_pkg::cause_t cs);
    jts_pkg::result_t r;
    r.kind   = k;
    r.start  = 16'(s);
    r.length = len;
    r.cause  = cs;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic jts_pkg::result_t run_tok(input jts_pkg::mode_t md, input logic [2:0] kc,
                                               input pos_t s, input logic [15:0] len);
    jts_pkg::kind_t k;
    k = jts_pkg::KIND_NUMBER;
    if (md == jts_pkg::MODE_WORD) begin
      if (kc[0] && (len == 16'd4)) k = jts_pkg::KIND_NULL;
      else if (kc[1] && (len == 16'd4)) k = jts_pkg::KIND_TRUE;
      else if (kc[2] && (len == 16'd5)) k = jts_pkg::KIND_FALSE;
      else k = jts_pkg::KIND_STRING;
    end
    return mk_tok(k, s, len, jts_pkg::CAUSE_NONE);
  endfunction

  assign in_chan.ready = !vld_r || (cnt_r <= 3'd1);
  assign in_take       = in_chan.valid && in_chan.ready;
  assign mv            = vld_r && (cnt_r <= 3'd1);
  assign vld_nxt       = in_take || (vld_r && !mv);
  assign p1            = pos_r + pos_t'(1);

  always_comb begin
    mode_nxt   = mode_r;
    esc_nxt    = esc_r;
    pos_nxt    = pos_r;
    rstart_nxt = rstart_r;
    rlen_nxt   = rlen_r;
    kc_nxt     = kc_r;
    halt_nxt   = halt_r;
    n_res      = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end
    if (halt_r) begin
      if (eot_r) begin
        mode_nxt   = jts_pkg::MODE_IDLE;
        esc_nxt    = 1'b0;
        pos_nxt    = '0;
        rstart_nxt = '0;
        rlen_nxt   = '0;
        kc_nxt     = 3'b111;
        halt_nxt   = 1'b0;
      end else begin
        pos_nxt = p1;
      end
    end else begin
      if (byte_r == jts_pkg::CH_NUL) begin
        if (mode_nxt == jts_pkg::MODE_STR) begin
          res[n_res] = mk_tok(jts_pkg::KIND_ERROR, pos_r, 16'd0,
                              jts_pkg::CAUSE_UNTERMINATED);
          n_res = n_res + 2'd1;
        end else begin
          if ((mode_nxt == jts_pkg::MODE_NUM) || (mode_nxt == jts_pkg::MODE_WORD)) begin
            res[n_res] = run_tok(mode_nxt, kc_nxt, rstart_nxt, rlen_nxt);
            n_res = n_res + 2'd1;
          end
          res[n_res] = mk_tok(jts_pkg::KIND_END, pos_r, 16'd0, jts_pkg::CAUSE_NONE);
          n_res = n_res + 2'd1;
        end
        mode_nxt = jts_pkg::MODE_IDLE;
        halt_nxt = 1'b1;
      end else if (mode_nxt == jts_pkg::MODE_STR) begin
        if (byte_r == jts_pkg::CH_LF) begin
          res[n_res] = mk_tok(jts_pkg::KIND_ERROR, pos_r, 16'd0, jts_pkg::CAUSE_NEWLINE);
          n_res = n_res + 2'd1;
          mode_nxt = jts_pkg::MODE_IDLE;
          halt_nxt = 1'b1;
        end else if (byte_r == jts_pkg::CH_BSLASH) begin
          esc_nxt  = !esc_nxt;
          rlen_nxt = sat_inc(rlen_nxt);
        end else if ((byte_r == jts_pkg::CH_QUOTE) && !esc_nxt) begin
          res[n_res] = mk_tok(jts_pkg::KIND_STRING, rstart_nxt, rlen_nxt,
                              jts_pkg::CAUSE_NONE);
          n_res = n_res + 2'd1;
          mode_nxt = jts_pkg::MODE_IDLE;
        end else begin
          esc_nxt  = 1'b0;
          rlen_nxt = sat_inc(rlen_nxt);
        end
      end else begin
        unique case (mode_nxt)
          jts_pkg::MODE_NUM: begin
            if (is_num_cont(byte_r)) begin
              rlen_nxt = sat_inc(rlen_nxt);
            end else begin
              res[n_res] = run_tok(mode_nxt, kc_nxt, rstart_nxt, rlen_nxt);
              n_res = n_res + 2'd1;
              mode_nxt = jts_pkg::MODE_IDLE;
            end
          end
          jts_pkg::MODE_WORD: begin
            if (is_alpha(byte_r)) begin
              kc_nxt   = kc_nxt & jts_pkg::kw_hits(rlen_nxt, byte_r);
              rlen_nxt = sat_inc(rlen_nxt);
            end else begin
              res[n_res] = run_tok(mode_nxt, kc_nxt, rstart_nxt, rlen_nxt);
              n_res = n_res + 2'd1;
              mode_nxt = jts_pkg::MODE_IDLE;
            end
          end
          default: begin
          end
        endcase
        if (mode_nxt == jts_pkg::MODE_IDLE) begin
          case (byte_r) inside
            jts_pkg::CH_SPACE, jts_pkg::CH_TAB, jts_pkg::CH_LF, jts_pkg::CH_CR: begin
            end
            jts_pkg::CH_QUOTE: begin
              mode_nxt   = jts_pkg::MODE_STR;
              rstart_nxt = p1;
              rlen_nxt   = '0;
              esc_nxt    = 1'b0;
            end
            [jts_pkg::CH_D0:jts_pkg::CH_D9], jts_pkg::CH_MINUS, jts_pkg::CH_PLUS: begin
              mode_nxt   = jts_pkg::MODE_NUM;
              rstart_nxt = pos_r;
              rlen_nxt   = 16'd1;
            end
            [jts_pkg::CH_LA:jts_pkg::CH_LZ], [jts_pkg::CH_UA:jts_pkg::CH_UZ]: begin
              mode_nxt   = jts_pkg::MODE_WORD;
              rstart_nxt = pos_r;
              rlen_nxt   = 16'd1;
              kc_nxt     = jts_pkg::kw_hits(16'd0, byte_r);
            end
            jts_pkg::CH_COMMA: begin
              res[n_res] = mk_tok(jts_pkg::KIND_COMMA, pos_r, 16'd1, jts_pkg::CAUSE_NONE);
              n_res = n_res + 2'd1;
            end
            jts_pkg::CH_COLON: begin
              res[n_res] = mk_tok(jts_pkg::KIND_COLON, pos_r, 16'd1, jts_pkg::CAUSE_NONE);
              n_res = n_res + 2'd1;
            end
            jts_pkg::CH_LBRACE: begin
              res[n_res] = mk_tok(jts_pkg::KIND_LBRACE, pos_r, 16'd1, jts_pkg::CAUSE_NONE);
              n_res = n_res + 2'd1;
            end
            jts_pkg::CH_RBRACE: begin
              res[n_res] = mk_tok(jts_pkg::KIND_RBRACE, pos_r, 16'd1, jts_pkg::CAUSE_NONE);
              n_res = n_res + 2'd1;
            end
            jts_pkg::CH_LBRKT: begin
              res[n_res] = mk_tok(jts_pkg::KIND_LBRACKET, pos_r, 16'd1,
                                  jts_pkg::CAUSE_NONE);
              n_res = n_res + 2'd1;
            end
            jts_pkg::CH_RBRKT: begin
              res[n_res] = mk_tok(jts_pkg::KIND_RBRACKET, pos_r, 16'd1,
                                  jts_pkg::CAUSE_NONE);
              n_res = n_res + 2'd1;
            end
            default: begin
              res[n_res] = mk_tok(jts_pkg::KIND_ERROR, pos_r, 16'd0,
                                  jts_pkg::CAUSE_UNEXPECTED);
              n_res = n_res + 2'd1;
              halt_nxt = 1'b1;
            end
          endcase
        end
      end
      if (eot_r) begin
        if (!halt_nxt) begin
          if (mode_nxt == jts_pkg::MODE_STR) begin
            res[n_res] = mk_tok(jts_pkg::KIND_ERROR, pos_r, 16'd0,
                                jts_pkg::CAUSE_UNTERMINATED);
            n_res = n_res + 2'd1;
          end else begin
            if ((mode_nxt == jts_pkg::MODE_NUM) || (mode_nxt == jts_pkg::MODE_WORD)) begin
              res[n_res] = run_tok(mode_nxt, kc_nxt, rstart_nxt, rlen_nxt);
              n_res = n_res + 2'd1;
            end
            res[n_res] = mk_tok(jts_pkg::KIND_END, p1, 16'd0, jts_pkg::CAUSE_NONE);
            n_res = n_res + 2'd1;
          end
        end
        mode_nxt   = jts_pkg::MODE_IDLE;
        esc_nxt    = 1'b0;
        pos_nxt    = '0;
        rstart_nxt = '0;
        rlen_nxt   = '0;
        kc_nxt     = 3'b111;
        halt_nxt   = 1'b0;
      end else begin
        pos_nxt = p1;
      end
    end
    if (n_res != 2'd0) begin
      res[n_res - 2'd1].last = 1'b1;
    end
  end

  // The result queue shifts toward entry 0 on a pop; new results land behind
  // whatever is left.
  assign pop = (cnt_r != 3'd0) && out_chan.ready;
  assign rem = cnt_r - {2'b00, pop};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[3] = q_r[3];
    if (mv) begin
      for (int j = 0; j < 3; j++) begin
        if (2'(j) < n_res) begin
          q_nxt[2'(rem + 3'(j))] = res[j];
        end
      end
      cnt_nxt = rem + {1'b0, n_res};
    end else begin
      cnt_nxt = rem;
    end
  end

  assign out_chan.valid        = (cnt_r != 3'd0);
  assign out_chan.token_kind   = q_r[0].kind;
  assign out_chan.token_start  = q_r[0].start;
  assign out_chan.token_length = q_r[0].length;
  assign out_chan.error_cause  = q_r[0].cause;
  assign out_chan.last_of_run  = q_r[0].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      cnt_r    <= '0;
      mode_r   <= jts_pkg::MODE_IDLE;
      esc_r    <= 1'b0;
      pos_r    <= '0;
      rstart_r <= '0;
      rlen_r   <= '0;
      kc_r     <= 3'b111;
      halt_r   <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
      if (mv) begin
        mode_r   <= mode_nxt;
        esc_r    <= esc_nxt;
        pos_r    <= pos_nxt;
        rstart_r <= rstart_nxt;
        rlen_r   <= rlen_nxt;
        kc_r     <= kc_nxt;
        halt_r   <= halt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_chan.text_byte;
      eot_r  <= in_chan.end_of_text;
    end
    for (int i = 0; i < 4; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

// ----- hw/rtl/jts_checker.sv -----
// ----------------------------------------------------------------------------
// JSON token scanner checker
// Port-level checks on the token stream, bound to the scanner's top level.
// ----------------------------------------------------------------------------
`include "json_token_scanner_unit_assert.svh"

module jts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  token_kind,
  input logic [15:0] token_length,
  input logic [1:0]  error_cause,
  input logic        last_of_run
);

  `JTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_length), "token changed or dropped while stalled")
  `JTS_ASSERT_NOW(a_kind_legal, out_valid, (token_kind != 4'd12) && (token_kind != 4'd14) && (token_kind != 4'd15), "undefined token kind")
  `JTS_ASSERT_NOW(a_cause_match, out_valid, (token_kind == jts_pkg::KIND_ERROR) == (error_cause != jts_pkg::CAUSE_NONE), "error cause disagrees with token kind")
  `JTS_ASSERT_NOW(a_final_tok, out_valid && ((token_kind == jts_pkg::KIND_END) || (token_kind == jts_pkg::KIND_ERROR)), last_of_run && (token_length == 16'd0), "end or error token not last or has a length")

endmodule

bind json_token_scanner_unit jts_checker u_jts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .token_kind   (out_chan.token_kind),
  .token_length (out_chan.token_length),
  .error_cause  (out_chan.error_cause),
  .last_of_run  (out_chan.last_of_run)
);

// ----- tb/sv/tb_json_token_scanner_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token scanner testbench
// Streams short JSON texts, broken texts and raw noise through the scanner
// under several idle and stall patterns, predicts every token in step with
// the accepted bytes and compares each token field by field.
// ----------------------------------------------------------------------------
module tb_json_token_scanner_unit;
  import jts_pkg::*;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  localparam logic [39:0] WORD_NULL  = "null";
  localparam logic [39:0] WORD_TRUE  = "true";
  localparam logic [39:0] WORD_FALSE = "false";
  localparam int          RANDOM_BYTES_PER_PHASE = 36;

  logic clk;
  logic rst_n;

  jts_in_if  in_chan ();
  jts_out_if out_chan ();

  json_token_scanner_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Scanner state as predicted from the accepted bytes.
  mode_t       scan_mode;
  logic        escape_armed;
  offset_t     byte_pos;
  offset_t     span_start;
  logic [15:0] span_len;
  logic [2:0]  keyword_live;
  logic        scan_halted;

  result_t     step_tokens[$];
  result_t     expected_tokens[$];
  text_item_t  text_queue[$];
  text_item_t  next_item;
  logic [7:0]  text_buf[$];

  int fail_count = 0;
  int tokens_checked = 0;
  int bytes_sent = 0;
  int texts_sent = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("** json_token_scanner_unit: FAILED **");
    $finish;
  end

  task automatic reset_scanner();
    scan_mode    = MODE_IDLE;
    escape_armed = 1'b0;
    byte_pos     = '0;
    span_start   = '0;
    span_len     = '0;
    keyword_live = 3'b111;
    scan_halted  = 1'b0;
  endtask

  task automatic add_token(input kind_t kind, input offset_t start, input logic [15:0] length,
                           input cause_t cause);
    result_t tok;
    tok.kind   = kind;
    tok.start  = start;
    tok.length = length;
    tok.cause  = cause;
    tok.last   = 1'b0;
    step_tokens.push_back(tok);
  endtask

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_D0 && c <= CH_D9;
  endfunction

  function automatic logic is_num_cont(input logic [7:0] c);
    return is_digit(c) || (c >= CH_LA && c <= CH_LF_HEX) || (c >= CH_UA && c <= CH_UF) ||
           c == CH_DOT || c == CH_MINUS || c == CH_PLUS;
  endfunction

  function automatic logic [7:0] keyword_char(input logic [39:0] word, input int unsigned word_len,
                                              input logic [15:0] idx);
    return word[8*(word_len-1-idx) +: 8];
  endfunction

  task automatic word_append(input logic [7:0] c);
    if (!(span_len < 16'd4 && c == keyword_char(WORD_NULL, 4, span_len))) keyword_live[0] = 1'b0;
    if (!(span_len < 16'd4 && c == keyword_char(WORD_TRUE, 4, span_len))) keyword_live[1] = 1'b0;
    if (!(span_len < 16'd5 && c == keyword_char(WORD_FALSE, 5, span_len))) keyword_live[2] = 1'b0;
    span_len = sat_inc(span_len);
  endtask

  task automatic flush_run();
    kind_t kind;
    if (scan_mode == MODE_NUM) begin
      add_token(KIND_NUMBER, span_start, span_len, CAUSE_NONE);
    end else if (scan_mode == MODE_WORD) begin
      kind = KIND_STRING;
      if (keyword_live[0] && span_len == 16'd4) kind = KIND_NULL;
      else if (keyword_live[1] && span_len == 16'd4) kind = KIND_TRUE;
      else if (keyword_live[2] && span_len == 16'd5) kind = KIND_FALSE;
      add_token(kind, span_start, span_len, CAUSE_NONE);
    end
    scan_mode = MODE_IDLE;
  endtask

  task automatic raise_error(input cause_t cause);
    add_token(KIND_ERROR, byte_pos, 16'd0, cause);
    scan_mode   = MODE_IDLE;
    scan_halted = 1'b1;
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic eot);
    result_t tok;
    step_tokens.delete();
    if (scan_halted) begin
      if (eot) reset_scanner();
      else byte_pos = byte_pos + 1'b1;
      return;
    end
    if (c == CH_NUL) begin
      if (scan_mode == MODE_STR) begin
        raise_error(CAUSE_UNTERMINATED);
      end else begin
        flush_run();
        add_token(KIND_END, byte_pos, 16'd0, CAUSE_NONE);
        scan_halted = 1'b1;
      end
    end else if (scan_mode == MODE_STR) begin
      if (c == CH_LF) begin
        raise_error(CAUSE_NEWLINE);
      end else if (c == CH_BSLASH) begin
        escape_armed = !escape_armed;
        span_len = sat_inc(span_len);
      end else if (c == CH_QUOTE && !escape_armed) begin
        add_token(KIND_STRING, span_start, span_len, CAUSE_NONE);
        scan_mode = MODE_IDLE;
      end else begin
        escape_armed = 1'b0;
        span_len = sat_inc(span_len);
      end
    end else begin
      if (scan_mode == MODE_NUM) begin
        if (is_num_cont(c)) span_len = sat_inc(span_len);
        else flush_run();
      end else if (scan_mode == MODE_WORD) begin
        if (is_alpha(c)) word_append(c);
        else flush_run();
      end
      if (scan_mode == MODE_IDLE) begin
        if (c == CH_QUOTE) begin
          scan_mode    = MODE_STR;
          span_start   = byte_pos + 1'b1;
          span_len     = '0;
          escape_armed = 1'b0;
        end else if (is_digit(c) || c == CH_MINUS || c == CH_PLUS) begin
          scan_mode  = MODE_NUM;
          span_start = byte_pos;
          span_len   = 16'd1;
        end else if (is_alpha(c)) begin
          scan_mode    = MODE_WORD;
          span_start   = byte_pos;
          span_len     = '0;
          keyword_live = 3'b111;
          word_append(c);
        end else if (c != CH_SPACE && c != CH_TAB && c != CH_LF && c != CH_CR) begin
          case (c)
            CH_COMMA:  add_token(KIND_COMMA, byte_pos, 16'd1, CAUSE_NONE);
            CH_COLON:  add_token(KIND_COLON, byte_pos, 16'd1, CAUSE_NONE);
            CH_LBRACE: add_token(KIND_LBRACE, byte_pos, 16'd1, CAUSE_NONE);
            CH_RBRACE: add_token(KIND_RBRACE, byte_pos, 16'd1, CAUSE_NONE);
            CH_LBRKT:  add_token(KIND_LBRACKET, byte_pos, 16'd1, CAUSE_NONE);
            CH_RBRKT:  add_token(KIND_RBRACKET, byte_pos, 16'd1, CAUSE_NONE);
            default:   raise_error(CAUSE_UNEXPECTED);
          endcase
        end
      end
    end
    if (eot) begin
      if (!scan_halted) begin
        if (scan_mode == MODE_STR) begin
          raise_error(CAUSE_UNTERMINATED);
        end else begin
          flush_run();
          add_token(KIND_END, byte_pos + 1'b1, 16'd0, CAUSE_NONE);
        end
      end
      reset_scanner();
    end else begin
      byte_pos = byte_pos + 1'b1;
    end
    if (step_tokens.size() != 0) begin
      tok = step_tokens.pop_back();
      tok.last = 1'b1;
      step_tokens.push_back(tok);
    end
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  task automatic check_token();
    result_t want;
    tokens_checked++;
    if (expected_tokens.size() == 0) begin
      $error("unexpected token: kind %0d start %0d length %0d", out_chan.token_kind,
             out_chan.token_start, out_chan.token_length);
      fail_count++;
      return;
    end
    want = expected_tokens.pop_front();
    if (out_chan.token_kind !== want.kind) begin
      $error("token_kind: expected %0d, got %0d", want.kind, out_chan.token_kind);
      fail_count++;
    end
    if (out_chan.token_start !== want.start) begin
      $error("token_start: expected %0d, got %0d", want.start, out_chan.token_start);
      fail_count++;
    end
    if (out_chan.token_length !== want.length) begin
      $error("token_length: expected %0d, got %0d", want.length, out_chan.token_length);
      fail_count++;
    end
    if (out_chan.error_cause !== want.cause) begin
      $error("error_cause: expected %0d, got %0d", want.cause, out_chan.error_cause);
      fail_count++;
    end
    if (out_chan.last_of_run !== want.last) begin
      $error("last_of_run: expected %0d, got %0d", want.last, out_chan.last_of_run);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        scan_byte(in_chan.text_byte, in_chan.end_of_text);
        bytes_sent++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (text_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = text_queue.pop_front();
          in_chan.text_byte   <= next_item.text_byte;
          in_chan.end_of_text <= next_item.end_of_text;
          in_chan.valid       <= 1'b1;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) check_token();
      out_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic logic [7:0] pick_char(input string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  task automatic queue_byte(input logic [7:0] c, input logic eot);
    text_item_t item;
    item.text_byte   = c;
    item.end_of_text = eot;
    text_queue.push_back(item);
  endtask

  task automatic queue_string(input string s, input logic eot_on_last);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], eot_on_last && i == s.len() - 1);
  endtask

  task automatic queue_buf(input logic eot_on_last);
    foreach (text_buf[i]) queue_byte(text_buf[i], eot_on_last && i == text_buf.size() - 1);
  endtask

  task automatic queue_ignored_tail();
    repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
    queue_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic buf_string_body();
    logic [7:0] c;
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 9))
        0: begin
          text_buf.push_back(CH_BSLASH);
          text_buf.push_back(pick_char("\"\\nabc"));
        end
        1: text_buf.push_back(8'($urandom_range(128, 255)));
        default: begin
          c = 8'($urandom_range(32, 126));
          if (c == CH_QUOTE || c == CH_BSLASH) c = CH_UA;
          text_buf.push_back(c);
        end
      endcase
    end
  endtask

  task automatic buf_token();
    string word;
    int    word_len;
    case ($urandom_range(0, 7))
      0, 1: text_buf.push_back(pick_char(",:{}[]"));
      2: begin
        text_buf.push_back(pick_char("0123456789-+"));
        repeat ($urandom_range(0, 4)) text_buf.push_back(pick_char("0123456789abcdefABCDEF.-+"));
      end
      3, 4: begin
        case ($urandom_range(0, 2))
          0: word = "null";
          1: word = "true";
          default: word = "false";
        endcase
        word_len = word.len();
        if ($urandom_range(0, 3) == 2) word_len--;
        for (int i = 0; i < word_len; i++) text_buf.push_back(word[i]);
        if ($urandom_range(0, 3) == 3)
          text_buf.push_back(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
      end
      5: begin
        repeat ($urandom_range(1, 6))
          text_buf.push_back(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
      end
      default: begin
        text_buf.push_back(CH_QUOTE);
        buf_string_body();
        text_buf.push_back(CH_QUOTE);
      end
    endcase
  endtask

  task automatic queue_random_text(inout int counted);
    int roll;
    text_buf.delete();
    repeat ($urandom_range(1, 6)) begin
      buf_token();
      if ($urandom_range(0, 1)) text_buf.push_back(pick_char(" \t\r\n"));
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      queue_buf(1'b1);
    end else if (roll < 70) begin
      text_buf.push_back(CH_NUL);
      queue_buf(1'b0);
      queue_ignored_tail();
    end else if (roll < 78) begin
      text_buf.push_back(CH_QUOTE);
      buf_string_body();
      text_buf.push_back(CH_LF);
      queue_buf(1'b0);
      queue_ignored_tail();
    end else if (roll < 86) begin
      text_buf.push_back(CH_QUOTE);
      buf_string_body();
      if ($urandom_range(0, 1)) begin
        queue_buf(1'b1);
      end else begin
        text_buf.push_back(CH_NUL);
        queue_buf(1'b0);
        queue_ignored_tail();
      end
    end else if (roll < 93) begin
      if ($urandom_range(0, 1)) text_buf.push_back(pick_char("#!@/\\=~"));
      else text_buf.push_back(8'($urandom_range(128, 255)));
      queue_buf(1'b0);
      queue_ignored_tail();
    end else begin
      text_buf.delete();
      repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
      queue_buf(1'b1);
    end
    counted += text_buf.size();
    texts_sent++;
  endtask

  task automatic drain();
    while (text_queue.size() != 0 || in_chan.valid || expected_tokens.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int counted;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.text_byte = '0;
    in_chan.end_of_text = 1'b0;
    out_chan.ready = 1'b0;
    reset_scanner();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
        default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
      endcase
      if (phase == 0) begin
        queue_string("{\"\\\"\":[-9,null]}", 1'b1);
        queue_string("x\r", 1'b0);
        queue_byte(CH_NUL, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_string("\"\n", 1'b1);
        queue_string("\"", 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_string("\"", 1'b0);
        queue_byte(CH_NUL, 1'b1);
        texts_sent += 6;
      end
      counted = 0;
      while (counted < RANDOM_BYTES_PER_PHASE) queue_random_text(counted);
      drain();
    end
    repeat (16) @(negedge clk);

    $display("Scanned %0d texts (%0d bytes) and checked %0d tokens across four idle/stall mixes,",
             texts_sent, bytes_sent, tokens_checked);
    $display("with well-formed, broken and noise texts ending by end of text or a zero byte.");
    if (fail_count == 0) begin
      $display("** json_token_scanner_unit: PASSED **");
    end else begin
      $display("** json_token_scanner_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/jts_pkg.sv
hw/rtl/jts_if.sv
hw/rtl/json_token_scanner_unit.sv
hw/rtl/jts_checker.sv
tb/sv/tb_json_token_scanner_unit.sv
